// ----- rtl/estc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// estc_pkg: shared types, constants and arithmetic helpers
// Trim register layout, queue entry, divider tag and wrapping multiply and
// shift functions used by the front and back of the compensation core.
// ----------------------------------------------------------------------------
package estc_pkg;

  // stream payload widths
  localparam int InDataW  = 56;
  localparam int OutDataW = 88;

  // APB port
  localparam int AddrW = 6;
  localparam int CfgW  = 64;

  // front-to-back queue
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;
  localparam int QCntW  = 3;

  // pipelined divider: one quotient bit per stage
  localparam int DivBits = 64;

  // formula constants
  localparam logic [63:0] Fine128k   = 64'd128000;
  localparam logic [63:0] Press1M    = 64'd1048576;
  localparam logic [63:0] Mul3125    = 64'd3125;
  localparam logic [63:0] Bit47      = 64'h0000_8000_0000_0000;
  localparam logic [31:0] Fine76800  = 32'd76800;
  localparam logic [31:0] HumMax     = 32'd419430400;
  localparam logic [31:0] Hum2M      = 32'd2097152;
  localparam logic [31:0] Round16k   = 32'd16384;
  localparam logic [31:0] Off32k     = 32'd32768;
  localparam logic [31:0] Round8k    = 32'd8192;
  localparam logic [31:0] Round128   = 32'd128;

  // register indexes
  typedef enum logic [2:0] {
    RegTemp      = 3'd0,
    RegPressLow  = 3'd1,
    RegPressHigh = 3'd2,
    RegMixed     = 3'd3,
    RegHum       = 3'd4
  } reg_idx_t;

  // all trim registers as one bundle
  typedef struct packed {
    logic [47:0] temp;
    logic [63:0] press_low;
    logic [63:0] press_high;
    logic [47:0] mixed;
    logic [31:0] hum;
  } trim_t;

  // queue entry: fine temperature plus the raw readings still needed
  typedef struct packed {
    logic [31:0] fine;
    logic [19:0] rp;
    logic [15:0] rh;
  } qent_t;

  // side data that rides along with the divider
  typedef struct packed {
    logic [31:0] temp;
    logic [16:0] hum;
    logic        bad;
    logic        neg;
  } dtag_t;

  function automatic logic [31:0] sra32(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] sra64(input logic [63:0] x, input int unsigned n);
    return 64'($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // low 32 bits of a 32x32 product
  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return p[31:0];
  endfunction

  // low 64 bits of a 64x64 product from three 32x32 partial products
  function automatic logic [63:0] mul64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ll;
    logic [31:0] lh;
    logic [31:0] hl;
    ll = {32'd0, a[31:0]} * {32'd0, b[31:0]};
    lh = mul32(a[31:0], b[63:32]);
    hl = mul32(a[63:32], b[31:0]);
    return ll + {lh + hl, 32'd0};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/estc_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// estc_front: input stage and temperature pipeline
// Accepts raw sample items, computes the fine temperature in two register
// stages and pushes it with the raw pressure and humidity into the queue.
// ----------------------------------------------------------------------------
module estc_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [19:0]          rt,
  input  wire logic [19:0]          rp,
  input  wire logic [15:0]          rh,
  input  wire logic [47:0]          temp_trim,
  input  wire logic                 q_full,
  output logic                      push,
  output estc_pkg::qent_t           push_data
);
  import estc_pkg::*;

  logic        adv;
  logic        v1, v2;
  logic [19:0] rp1, rp2;
  logic [15:0] rh1, rh2;
  logic [31:0] tap, tdsq;
  logic [31:0] ta, tbp;
  logic [31:0] t1, t2, t3, td, tax;

  assign adv      = !q_full;
  assign in_ready = adv;
  assign push     = adv && v2;

  // trim fields
  assign t1 = {16'd0, temp_trim[15:0]};
  assign t2 = {{16{temp_trim[31]}}, temp_trim[31:16]};
  assign t3 = {{16{temp_trim[47]}}, temp_trim[47:32]};

  assign tax = {15'd0, rt[19:3]} - {t1[30:0], 1'b0};
  assign td  = {16'd0, rt[19:4]} - t1;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  // stage 1: raw products, stage 2: scaled products
  always_ff @(posedge clk) begin
    if (adv) begin
      rp1  <= rp;
      rh1  <= rh;
      tap  <= mul32(tax, t2);
      tdsq <= mul32(td, td);
      rp2  <= rp1;
      rh2  <= rh1;
      ta   <= sra32(tap, 11);
      tbp  <= mul32(sra32(tdsq, 12), t3);
    end
  end

  // fine temperature into the queue
  always_comb begin
    push_data.fine = ta + sra32(tbp, 14);
    push_data.rp   = rp2;
    push_data.rh   = rh2;
  end

endmodule
`default_nettype wire

// ----- rtl/estc_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// estc_queue: small FIFO between front and back
// Register-based queue that lets either side stall on its own.
// ----------------------------------------------------------------------------
module estc_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire estc_pkg::qent_t push_data,
  input  wire logic            pop,
  output estc_pkg::qent_t      pop_data,
  output logic                 full,
  output logic                 empty
);
  import estc_pkg::*;

  qent_t            mem [QDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QCntW-1:0] count;

  assign full     = (count == QCntW'(QDepth));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

// ----- rtl/estc_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// estc_div: pipelined unsigned 64-bit divider
// Restoring division, one quotient bit per stage, with a tag carried along.
// ----------------------------------------------------------------------------
module estc_div (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [63:0]      dividend,
  input  wire logic [63:0]      divisor,
  input  wire estc_pkg::dtag_t  in_tag,
  output logic                  out_valid,
  output logic [63:0]           quotient,
  output estc_pkg::dtag_t       out_tag
);
  import estc_pkg::*;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] num;
    logic [63:0] quo;
    logic [63:0] den;
    dtag_t       tag;
  } dstage_t;

  dstage_t st  [DivBits+1];
  logic    vld [DivBits+1];

  assign st[0]  = '{rem: '0, num: dividend, quo: '0, den: divisor, tag: in_tag};
  assign vld[0] = in_valid;

  for (genvar g = 1; g <= DivBits; g++) begin : g_stage
    logic [64:0] trial;
    logic        fits;
    dstage_t     nx;

    // shift in one dividend bit, subtract if it fits
    always_comb begin
      trial = {st[g-1].rem, st[g-1].num[63]};
      fits  = (trial >= {1'b0, st[g-1].den});
      nx     = st[g-1];
      nx.num = {st[g-1].num[62:0], 1'b0};
      nx.quo = {st[g-1].quo[62:0], fits};
      nx.rem = fits ? 64'(trial - {1'b0, st[g-1].den}) : trial[63:0];
    end

    always_ff @(posedge clk) begin
      if (rst)     vld[g] <= 1'b0;
      else if (en) vld[g] <= vld[g-1];
    end

    always_ff @(posedge clk) begin
      if (en) st[g] <= nx;
    end
  end

  assign out_valid = vld[DivBits];
  assign quotient  = st[DivBits].quo;
  assign out_tag   = st[DivBits].tag;

endmodule
`default_nettype wire

// ----- rtl/estc_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// estc_back: pressure and humidity pipeline with output register
// Takes fine temperature items from the queue, runs the pressure and
// humidity formulas through register stages and the divider, and holds
// the finished result in the output register.
// ----------------------------------------------------------------------------
module estc_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire estc_pkg::trim_t  trim,
  input  wire logic             q_empty,
  input  wire estc_pkg::qent_t  q_data,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [31:0]           temperature_centi,
  output logic [31:0]           pressure_q24_8,
  output logic [16:0]           humidity_q22_10,
  output logic                  pressure_invalid
);
  import estc_pkg::*;

  localparam int NS = 9;
  localparam int NT = 4;

  typedef struct packed {
    logic [19:0] rp;
    logic [15:0] rh;
    logic [31:0] temp;
    logic [63:0] x, xx, xp5, xp2, y, xa, x2, numb, x3, num, dvs, ma, mb;
    logic [31:0] v, lhsp, vh6, vh3, lhs, innp, rhsp, hv, hs, hsq, humv;
    logic [16:0] hum;
    logic        bad;
    logic        neg;
  } bk_t;

  typedef struct packed {
    dtag_t       tag;
    logic [63:0] q, sp, ep, c1, c, e;
  } pt_t;

  logic        en;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;
  bk_t         s [1:NS];
  bk_t         c [1:NS];
  logic        vs [1:NS];
  pt_t         t [1:NT];
  pt_t         u [1:NT];
  logic        vt [1:NT];
  logic        dv_valid;
  logic [63:0] dv_quo;
  dtag_t       dv_tag;
  logic [63:0] press;

  assign en  = !out_valid || out_ready;
  assign pop = en && !q_empty;

  // trim fields
  assign p1 = {48'd0, trim.press_low[15:0]};
  assign p2 = sx16(trim.press_low[31:16]);
  assign p3 = sx16(trim.press_low[47:32]);
  assign p4 = sx16(trim.press_low[63:48]);
  assign p5 = sx16(trim.press_high[15:0]);
  assign p6 = sx16(trim.press_high[31:16]);
  assign p7 = sx16(trim.press_high[47:32]);
  assign p8 = sx16(trim.press_high[63:48]);
  assign p9 = sx16(trim.mixed[15:0]);
  assign h1 = {24'd0, trim.mixed[23:16]};
  assign h2 = {{16{trim.mixed[39]}}, trim.mixed[39:24]};
  assign h3 = {24'd0, trim.mixed[47:40]};
  assign h4 = {{20{trim.hum[11]}}, trim.hum[11:0]};
  assign h5 = {{20{trim.hum[23]}}, trim.hum[23:12]};
  assign h6 = {{24{trim.hum[31]}}, trim.hum[31:24]};

  // stages ahead of the divider
  always_comb begin
    c[1]      = '0;
    c[1].rp   = q_data.rp;
    c[1].rh   = q_data.rh;
    c[1].x    = 64'($signed(q_data.fine)) - Fine128k;
    c[1].v    = q_data.fine - Fine76800;
    c[1].temp = sra32(mul32(q_data.fine, 32'd5) + Round128, 8);

    c[2]      = s[1];
    c[2].xx   = mul64(s[1].x, s[1].x);
    c[2].xp5  = mul64(s[1].x, p5);
    c[2].xp2  = mul64(s[1].x, p2);
    c[2].lhsp = {2'd0, s[1].rh, 14'd0} - {h4[11:0], 20'd0} - mul32(h5, s[1].v) + Round16k;
    c[2].vh6  = mul32(s[1].v, h6);
    c[2].vh3  = mul32(s[1].v, h3);

    c[3]      = s[2];
    c[3].y    = mul64(s[2].xx, p6) + (s[2].xp5 << 17) + (p4 << 35);
    c[3].xa   = mul64(s[2].xx, p3);
    c[3].lhs  = sra32(s[2].lhsp, 15);
    c[3].innp = mul32(sra32(s[2].vh6, 10), sra32(s[2].vh3, 11) + Off32k);

    c[4]      = s[3];
    c[4].x2   = sra64(s[3].xa, 8) + (s[3].xp2 << 12);
    c[4].rhsp = mul32(sra32(s[3].innp, 10) + Hum2M, h2) + Round8k;
    c[4].numb = ((Press1M - {44'd0, s[3].rp}) << 31) - s[3].y;

    c[5]      = s[4];
    c[5].x3   = mul64(s[4].x2 + Bit47, p1);
    c[5].hv   = mul32(s[4].lhs, sra32(s[4].rhsp, 14));
    c[5].num  = mul64(s[4].numb, Mul3125);

    c[6]      = s[5];
    c[6].dvs  = sra64(s[5].x3, 33);
    c[6].hs   = sra32(s[5].hv, 15);

    // magnitudes for the unsigned divider
    c[7]      = s[6];
    c[7].hsq  = sra32(mul32(s[6].hs, s[6].hs), 7);
    c[7].bad  = (s[6].dvs == '0);
    c[7].neg  = s[6].num[63] ^ s[6].dvs[63];
    c[7].ma   = s[6].num[63] ? 64'(64'd0 - s[6].num) : s[6].num;
    c[7].mb   = s[6].dvs[63] ? 64'(64'd0 - s[6].dvs) : s[6].dvs;

    c[8]      = s[7];
    c[8].humv = s[7].hv - sra32(mul32(s[7].hsq, h1), 4);

    // humidity clamp and final shift
    c[9]      = s[8];
    if (s[8].humv[31])            c[9].hum = '0;
    else if (s[8].humv > HumMax)  c[9].hum = HumMax[28:12];
    else                          c[9].hum = s[8].humv[28:12];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= NS; i++) vs[i] <= 1'b0;
    end else if (en) begin
      vs[1] <= pop;
      for (int i = 2; i <= NS; i++) vs[i] <= vs[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s[1] <= c[1];
      for (int i = 2; i <= NS; i++) s[i] <= c[i];
    end
  end

  // divider
  estc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vs[NS]),
    .dividend (s[NS].ma),
    .divisor  (s[NS].mb),
    .in_tag   ('{temp: s[NS].temp, hum: s[NS].hum, bad: s[NS].bad, neg: s[NS].neg}),
    .out_valid(dv_valid),
    .quotient (dv_quo),
    .out_tag  (dv_tag)
  );

  // correction terms after the divider
  always_comb begin
    u[1]     = '0;
    u[1].tag = dv_tag;
    u[1].q   = dv_tag.neg ? 64'(64'd0 - dv_quo) : dv_quo;

    u[2]     = t[1];
    u[2].sp  = sra64(t[1].q, 13);
    u[2].ep  = mul64(p8, t[1].q);

    u[3]     = t[2];
    u[3].c1  = mul64(p9, t[2].sp);

    u[4]     = t[3];
    u[4].c   = sra64(mul64(t[3].c1, t[3].sp), 25);
    u[4].e   = sra64(t[3].ep, 19);

    press    = sra64(t[4].q + t[4].c + t[4].e, 8) + (p7 << 4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= NT; i++) vt[i] <= 1'b0;
    end else if (en) begin
      vt[1] <= dv_valid;
      for (int i = 2; i <= NT; i++) vt[i] <= vt[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 1; i <= NT; i++) t[i] <= u[i];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst)     out_valid <= 1'b0;
    else if (en) out_valid <= vt[NT];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      temperature_centi <= t[NT].tag.temp;
      pressure_q24_8    <= t[NT].tag.bad ? 32'd0 : press[31:0];
      humidity_q22_10   <= t[NT].tag.hum;
      pressure_invalid  <= t[NT].tag.bad;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/env_sensor_trim_compensation_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// env_sensor_trim_compensation_core: integer trim compensation
// Computes compensated temperature, pressure and humidity from a raw
// sample item using trim coefficients held in APB registers.
//
//   channel  dir  handshake         payload
//   s_*      in   tvalid/tready     raw_temperature, raw_pressure, raw_humidity
//   m_*      out  tvalid/tready     temperature, pressure, humidity, invalid
//   APB      in   psel/penable      trim registers at 8*index
//
// One item per cycle sustained while m_tready holds. From the accepting edge
// to m_tvalid: 2 front stages, the queue write, 9 back stages, 64 divider
// stages (one quotient bit each), 4 post stages and the output register.
// Synchronous reset clears all valids, the queue and the trim registers. An
// output stall freezes the back pipeline; the front keeps accepting until
// the 4-entry queue is full.
// ----------------------------------------------------------------------------
module env_sensor_trim_compensation_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // raw_temperature [19:0], raw_pressure [39:20], raw_humidity [55:40]
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [estc_pkg::InDataW-1:0]  s_tdata,
  // temperature_centi [31:0], pressure_q24_8 [63:32], humidity_q22_10 [80:64]
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [estc_pkg::OutDataW-1:0]      m_tdata,
  // pressure_invalid [0]
  output logic                               m_tuser,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [estc_pkg::AddrW-1:0]    paddr,
  input  wire logic [estc_pkg::CfgW-1:0]     pwdata,
  output logic [estc_pkg::CfgW-1:0]          prdata,
  output logic                               pready
);
  import estc_pkg::*;

  trim_t       trim;
  reg_idx_t    idx;
  logic        wr;
  logic        q_full, q_empty, push, pop;
  qent_t       push_data, pop_data;
  logic [31:0] temp_o, press_o;
  logic [16:0] hum_o;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[5:3]);
  assign wr     = psel && penable && pwrite && pready;

  // trim register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      trim <= '0;
    end else if (wr) begin
      unique case (idx)
        RegTemp:      trim.temp       <= pwdata[47:0];
        RegPressLow:  trim.press_low  <= pwdata;
        RegPressHigh: trim.press_high <= pwdata;
        RegMixed:     trim.mixed      <= pwdata[47:0];
        RegHum:       trim.hum        <= pwdata[31:0];
        default:      ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (idx)
      RegTemp:      prdata = {16'd0, trim.temp};
      RegPressLow:  prdata = trim.press_low;
      RegPressHigh: prdata = trim.press_high;
      RegMixed:     prdata = {16'd0, trim.mixed};
      RegHum:       prdata = {32'd0, trim.hum};
      default:      prdata = '0;
    endcase
  end

  estc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .rt       (s_tdata[19:0]),
    .rp       (s_tdata[39:20]),
    .rh       (s_tdata[55:40]),
    .temp_trim(trim.temp),
    .q_full   (q_full),
    .push     (push),
    .push_data(push_data)
  );

  estc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .full     (q_full),
    .empty    (q_empty)
  );

  estc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .trim             (trim),
    .q_empty          (q_empty),
    .q_data           (pop_data),
    .pop              (pop),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .temperature_centi(temp_o),
    .pressure_q24_8   (press_o),
    .humidity_q22_10  (hum_o),
    .pressure_invalid (m_tuser)
  );

  assign m_tdata = {7'd0, hum_o, press_o, temp_o};

endmodule
`default_nettype wire
